/* src/knn_pkg.sv */
`default_nettype none

package knn_pkg;

    localparam int K_MAX_DEF = 16;
    localparam int D_MAX_DEF = 8;

    localparam int COORD_W = 16;
    localparam int LABEL_W = 8;
    localparam int CNT_W   = 5;
    localparam int NBR_W   = 5;
    localparam int DIMS_W  = 4;
    localparam int CFG_W   = 5;
    localparam int SQ_W    = 32;

    localparam logic CFG_NEIGHBOR_COUNT = 1'b0;
    localparam logic CFG_DIMS_IN_USE    = 1'b1;

    localparam logic [NBR_W-1:0]  NEIGHBOR_RESET = 5'd1;
    localparam logic [DIMS_W-1:0] DIMS_RESET     = 4'd2;

    typedef struct packed {
        logic               valid;
        logic [LABEL_W-1:0] predicted_class;
        logic [CNT_W-1:0]   vote_count;
        logic [CNT_W-1:0]   neighbors_used;
    } t_vote_res;

endpackage

`default_nettype wire

/* src/knn_dist_lane.sv */
`default_nettype none

module knn_dist_lane (
    input  wire                                    i_clk,
    input  wire                                    i_load,
    input  wire                                    i_enable,
    input  wire  signed [knn_pkg::COORD_W-1:0]     i_coord,
    input  wire  signed [knn_pkg::COORD_W-1:0]     i_query,
    output logic        [knn_pkg::SQ_W-1:0]        o_square
);

    logic signed [knn_pkg::COORD_W:0]     w_diff;
    logic signed [2*knn_pkg::COORD_W+1:0] w_prod;
    logic        [knn_pkg::SQ_W-1:0]      r_square;

    assign w_diff = {i_coord[knn_pkg::COORD_W-1], i_coord}
                  - {i_query[knn_pkg::COORD_W-1], i_query};
    assign w_prod = w_diff * w_diff;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_square <= i_enable ? w_prod[knn_pkg::SQ_W-1:0] : '0;
        end
    end

    assign o_square = r_square;

endmodule

`default_nettype wire

/* src/knn_sorted_list.sv */
`default_nettype none

module knn_sorted_list #(
    parameter int K_MAX  = knn_pkg::K_MAX_DEF,
    parameter int DIST_W = 35,
    parameter int CW     = 5
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_clear,
    input  wire                             i_insert,
    input  wire  [CW-1:0]                   i_k,
    input  wire  [DIST_W-1:0]               i_dist,
    input  wire  [knn_pkg::LABEL_W-1:0]     i_label,
    output logic [knn_pkg::LABEL_W-1:0]     o_labels [K_MAX],
    output logic [CW-1:0]                   o_filled
);

    logic [DIST_W-1:0]           r_dist [K_MAX];
    logic [knn_pkg::LABEL_W-1:0] r_lbl  [K_MAX];
    logic [CW-1:0]               r_filled;
    logic [CW-1:0]               w_n_cut;
    logic [K_MAX-1:0]            w_le;

    assign w_n_cut = (r_filled > i_k) ? i_k : r_filled;

    always_comb begin
        for (int j = 0; j < K_MAX; j++) begin
            w_le[j] = (CW'(j) < w_n_cut) && (r_dist[j] <= i_dist);
        end
    end

    // entries before the insertion point hold, the one at it takes the new
    // point, those after it move down by one
    for (genvar j = 0; j < K_MAX; j++) begin : g_entry
        always_ff @(posedge i_clk) begin
            if (i_insert && !w_le[j]) begin
                if (j == 0) begin
                    r_dist[j] <= i_dist;
                    r_lbl[j]  <= i_label;
                end else if (w_le[(j > 0) ? j - 1 : 0]) begin
                    r_dist[j] <= i_dist;
                    r_lbl[j]  <= i_label;
                end else begin
                    r_dist[j] <= r_dist[(j > 0) ? j - 1 : 0];
                    r_lbl[j]  <= r_lbl[(j > 0) ? j - 1 : 0];
                end
            end
        end
        assign o_labels[j] = r_lbl[j];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
        end else if (i_clear) begin
            r_filled <= '0;
        end else if (i_insert) begin
            r_filled <= (w_n_cut < i_k) ? w_n_cut + CW'(1) : w_n_cut;
        end
    end

    assign o_filled = r_filled;

endmodule

`default_nettype wire

/* src/knn_vote.sv */
`default_nettype none

module knn_vote #(
    parameter int K_MAX = knn_pkg::K_MAX_DEF,
    parameter int CW    = 5
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    input  wire  [knn_pkg::LABEL_W-1:0]  i_labels [K_MAX],
    input  wire  [CW-1:0]                i_n,
    output knn_pkg::t_vote_res           o_res
);

    localparam int KW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

    logic                        r_active;
    logic [CW-1:0]               r_idx;
    logic [knn_pkg::LABEL_W-1:0] r_best_lbl;
    logic [CW-1:0]               r_best_cnt;
    knn_pkg::t_vote_res          r_res;

    logic [knn_pkg::LABEL_W-1:0] w_cand;
    logic [K_MAX-1:0]            w_match;
    logic                        w_seen;
    logic [CW-1:0]               w_count;
    logic                        w_take;
    logic [knn_pkg::LABEL_W-1:0] w_lbl;
    logic [CW-1:0]               w_cnt;

    assign w_cand = i_labels[r_idx[KW-1:0]];

    always_comb begin
        w_seen  = 1'b0;
        w_count = '0;
        for (int j = 0; j < K_MAX; j++) begin
            w_match[j] = (CW'(j) < i_n) && (i_labels[j] == w_cand);
            if (w_match[j] && (CW'(j) < r_idx)) begin
                w_seen = 1'b1;
            end
            w_count = w_count + CW'(w_match[j]);
        end
    end

    // first label to reach a count wins a tie
    assign w_take = !w_seen && (w_count > r_best_cnt);
    assign w_lbl  = w_take ? w_cand  : r_best_lbl;
    assign w_cnt  = w_take ? w_count : r_best_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_res.valid <= 1'b0;
        end else begin
            r_res.valid <= 1'b0;
            if (i_start) begin
                r_active   <= 1'b1;
                r_idx      <= '0;
                r_best_cnt <= '0;
            end else if (r_active) begin
                r_best_lbl <= w_lbl;
                r_best_cnt <= w_cnt;
                if ((r_idx + CW'(1)) == i_n) begin
                    r_active              <= 1'b0;
                    r_res.valid           <= 1'b1;
                    r_res.predicted_class <= w_lbl;
                    r_res.vote_count      <= knn_pkg::CNT_W'(w_cnt);
                    r_res.neighbors_used  <= knn_pkg::CNT_W'(i_n);
                end else begin
                    r_idx <= r_idx + CW'(1);
                end
            end
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

/* src/knn_majority_classifier_top.sv */
`default_nettype none

// Query item: loads the query point and clears the list; busy stays low.
// Training item: distance lanes, sum, list insert. Final training item: these steps and then a
// vote over n = neighbours voting; the vote scans one list entry a cycle.
// Results are strobed for one cycle on o_valid; the receiver cannot stall.
// Synchronous active-low reset: registers k = 1, dims = 2, query point zero,
// list empty, block idle.

module knn_majority_classifier_top #(
    parameter int K_MAX = knn_pkg::K_MAX_DEF,
    parameter int D_MAX = knn_pkg::D_MAX_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire                                 i_cfg_we,
    input  wire                                 i_cfg_index,
    input  wire  [knn_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire                                 i_operation,
    input  wire  signed [knn_pkg::COORD_W-1:0]  i_coord_0,
    input  wire  signed [knn_pkg::COORD_W-1:0]  i_coord_1,
    input  wire  signed [knn_pkg::COORD_W-1:0]  i_coord_2,
    input  wire  signed [knn_pkg::COORD_W-1:0]  i_coord_3,
    input  wire  signed [knn_pkg::COORD_W-1:0]  i_coord_4,
    input  wire  signed [knn_pkg::COORD_W-1:0]  i_coord_5,
    input  wire  signed [knn_pkg::COORD_W-1:0]  i_coord_6,
    input  wire  signed [knn_pkg::COORD_W-1:0]  i_coord_7,
    input  wire  [knn_pkg::LABEL_W-1:0]         i_class_label,
    input  wire                                 i_last_point,
    output logic                                o_valid,
    output logic [knn_pkg::LABEL_W-1:0]         o_predicted_class,
    output logic [knn_pkg::CNT_W-1:0]           o_vote_count,
    output logic [knn_pkg::CNT_W-1:0]           o_neighbors_used
);

    localparam int CW     = $clog2(K_MAX + 1);
    localparam int DIST_W = knn_pkg::SQ_W + $clog2(D_MAX);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_INS  = 2'd2;
    localparam logic [1:0] ST_VOTE = 2'd3;

    logic [1:0]                  r_state;
    logic [knn_pkg::NBR_W-1:0]   r_neighbor_count;
    logic [knn_pkg::DIMS_W-1:0]  r_dims_in_use;
    logic signed [knn_pkg::COORD_W-1:0] r_query [D_MAX];
    logic [knn_pkg::LABEL_W-1:0] r_label;
    logic                        r_last;
    logic [DIST_W-1:0]           r_dist;

    logic signed [knn_pkg::COORD_W-1:0] w_coord [8];
    logic [knn_pkg::SQ_W-1:0]    w_square [D_MAX];
    logic [DIST_W-1:0]           w_sum;
    logic [CW-1:0]               w_eff_k;
    logic [knn_pkg::DIMS_W-1:0]  w_eff_d;
    logic                        w_accept;
    logic                        w_train;
    logic                        w_query;
    logic [knn_pkg::LABEL_W-1:0] w_labels [K_MAX];
    logic [CW-1:0]               w_filled;
    knn_pkg::t_vote_res          w_res;

    assign w_coord[0] = i_coord_0;
    assign w_coord[1] = i_coord_1;
    assign w_coord[2] = i_coord_2;
    assign w_coord[3] = i_coord_3;
    assign w_coord[4] = i_coord_4;
    assign w_coord[5] = i_coord_5;
    assign w_coord[6] = i_coord_6;
    assign w_coord[7] = i_coord_7;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_train  = w_accept && i_operation;
    assign w_query  = w_accept && !i_operation;

    always_comb begin
        if (r_neighbor_count == '0) begin
            w_eff_k = CW'(1);
        end else if (32'(r_neighbor_count) > 32'(K_MAX)) begin
            w_eff_k = CW'(K_MAX);
        end else begin
            w_eff_k = CW'(r_neighbor_count);
        end
        if (r_dims_in_use == '0) begin
            w_eff_d = knn_pkg::DIMS_W'(1);
        end else if (32'(r_dims_in_use) > 32'(D_MAX)) begin
            w_eff_d = knn_pkg::DIMS_W'(D_MAX);
        end else begin
            w_eff_d = r_dims_in_use;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neighbor_count <= knn_pkg::NEIGHBOR_RESET;
            r_dims_in_use    <= knn_pkg::DIMS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                knn_pkg::CFG_NEIGHBOR_COUNT: begin
                    r_neighbor_count <= i_cfg_data[knn_pkg::NBR_W-1:0];
                end
                knn_pkg::CFG_DIMS_IN_USE: begin
                    r_dims_in_use <= i_cfg_data[knn_pkg::DIMS_W-1:0];
                end
            endcase
        end
    end

    for (genvar d = 0; d < D_MAX; d++) begin : g_lane
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_query[d] <= '0;
            end else if (w_query) begin
                r_query[d] <= w_coord[d];
            end
        end

        knn_dist_lane u_lane (
            .i_clk    (i_clk),
            .i_load   (w_train),
            .i_enable (32'(d) < 32'(w_eff_d)),
            .i_coord  (w_coord[d]),
            .i_query  (r_query[d]),
            .o_square (w_square[d])
        );
    end

    always_comb begin
        w_sum = '0;
        for (int d = 0; d < D_MAX; d++) begin
            w_sum = w_sum + DIST_W'(w_square[d]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_train) begin
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    r_state <= ST_INS;
                end
                ST_INS: begin
                    r_state <= r_last ? ST_VOTE : ST_IDLE;
                end
                ST_VOTE: begin
                    if (w_res.valid) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_train) begin
            r_label <= i_class_label;
            r_last  <= i_last_point;
        end
        if (r_state == ST_SUM) begin
            r_dist <= w_sum;
        end
    end

    knn_sorted_list #(
        .K_MAX  (K_MAX),
        .DIST_W (DIST_W),
        .CW     (CW)
    ) u_list (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_query),
        .i_insert (r_state == ST_INS),
        .i_k      (w_eff_k),
        .i_dist   (r_dist),
        .i_label  (r_label),
        .o_labels (w_labels),
        .o_filled (w_filled)
    );

    knn_vote #(
        .K_MAX (K_MAX),
        .CW    (CW)
    ) u_vote (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  ((r_state == ST_INS) && r_last),
        .i_labels (w_labels),
        .i_n      (w_filled),
        .o_res    (w_res)
    );

    assign o_valid           = w_res.valid;
    assign o_predicted_class = w_res.predicted_class;
    assign o_vote_count      = w_res.vote_count;
    assign o_neighbors_used  = w_res.neighbors_used;

`ifndef NO_ASSERTIONS
    a_result_from_vote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == ST_VOTE))
        else $error("result transfer outside vote phase");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_list_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INS) |=> (w_filled <= w_eff_k) && (w_filled != '0))
        else $error("neighbour count out of range after insert");

    a_train_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_train |=> busy && (r_state == ST_SUM))
        else $error("training transfer did not start distance sum");
`endif

endmodule

`default_nettype wire
